// ----- sv/rae_pkg.sv -----
// ----------------------------------------------------------------------------
// Register ALU execute package
// Beat types, decoded operations, back-end states and index helpers shared by
// the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package rae_pkg;

  localparam int CMD_W          = 4;
  localparam int IDX_FIELD_W    = 3;
  localparam int IMM_W          = 31;
  localparam int DEST_W         = 32;
  localparam int IDX_W          = 5;
  localparam int QDEPTH         = 2;
  localparam int NUM_REGS_DEF   = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [CMD_W-1:0] CMD_MOV = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ADD = 4'd1;
  localparam logic [CMD_W-1:0] CMD_SUB = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 4'd3;
  localparam logic [CMD_W-1:0] CMD_MUL = 4'd4;
  localparam logic [CMD_W-1:0] CMD_AND = 4'd5;
  localparam logic [CMD_W-1:0] CMD_OR  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_XOR = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CMP = 4'd8;

  typedef enum logic [3:0] {
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_DIV,
    OP_MUL,
    OP_AND,
    OP_OR,
    OP_XOR,
    OP_CMP,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ITER,
    ST_DONE
  } bst_t;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [IDX_FIELD_W-1:0] dest_index;
    logic                   use_immediate;
    logic [IDX_FIELD_W-1:0] src_index;
    logic [IMM_W-1:0]       imm_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DEST_W-1:0] dest_value;
    logic                     greater_flag;
    logic                     equal_flag;
    logic                     div_zero_error;
  } out_beat_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] dest_index;
    logic [IDX_W-1:0] src_index;
    logic             use_immediate;
    logic [IMM_W-1:0] imm_value;
  } q_beat_t;

  typedef struct packed {
    logic    valid;
    q_beat_t beat;
  } issue_t;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_FIELD_W-1:0] idx,
                                                input int n);
    logic [IDX_W-1:0] v;
    v = IDX_W'(idx);
    for (int k = 0; k < 8; k++) begin
      if (int'(v) >= n) begin
        v = v - IDX_W'(n);
      end
    end
    return v;
  endfunction

endpackage

// ----- sv/register_alu_execute_core.sv -----
// ----------------------------------------------------------------------------
// Register ALU execute core
// Two-operand ALU over a small signed register file with compare flags.
// ----------------------------------------------------------------------------
// Each input beat executes one instruction and yields one result beat. Mov,
// add, sub, and, or, xor, cmp, unused commands and a divide by zero go
// through the back end as queue pop, register file read and write back; mul
// and a divide by a nonzero value also iterate over DATA_WIDTH bits in the
// one-bit-per-cycle shift-add multiplier and restoring divider before write
// back. A two-beat queue in front and an output register behind let input
// and output stall independently.
module register_alu_execute_core #(
  parameter int NUM_REGS   = rae_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH = rae_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rae_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output rae_pkg::out_beat_t out_beat
);

  rae_pkg::issue_t issue;
  logic            issue_pop;

  rae_front #(
    .NUM_REGS(NUM_REGS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .issue     (issue),
    .issue_pop (issue_pop)
  );

  rae_back #(
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .issue_pop (issue_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

// ----- sv/rae_ram.sv -----
// ----------------------------------------------------------------------------
// Register ALU generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module rae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// ----- sv/rae_front.sv -----
// ----------------------------------------------------------------------------
// Register ALU front end
// Accepts instruction beats, decodes the command, wraps register numbers and
// holds the decoded beats in a short queue for the back end.
// ----------------------------------------------------------------------------
module rae_front #(
  parameter int NUM_REGS = rae_pkg::NUM_REGS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rae_pkg::in_beat_t in_beat,
  output rae_pkg::issue_t   issue,
  input  logic              issue_pop
);

  localparam int QAW = $clog2(rae_pkg::QDEPTH);
  localparam int QCW = $clog2(rae_pkg::QDEPTH + 1);

  rae_pkg::q_beat_t q_mem_r [rae_pkg::QDEPTH];
  logic [QAW-1:0]   wptr_r;
  logic [QAW-1:0]   rptr_r;
  logic [QCW-1:0]   cnt_r;
  rae_pkg::q_beat_t dec;
  logic             push;

  always_comb begin
    dec.dest_index    = rae_pkg::wrap_idx(in_beat.dest_index, NUM_REGS);
    dec.src_index     = rae_pkg::wrap_idx(in_beat.src_index, NUM_REGS);
    dec.use_immediate = in_beat.use_immediate;
    dec.imm_value     = in_beat.imm_value;
    unique case (in_beat.cmd)
      rae_pkg::CMD_MOV: dec.op = rae_pkg::OP_MOV;
      rae_pkg::CMD_ADD: dec.op = rae_pkg::OP_ADD;
      rae_pkg::CMD_SUB: dec.op = rae_pkg::OP_SUB;
      rae_pkg::CMD_DIV: dec.op = rae_pkg::OP_DIV;
      rae_pkg::CMD_MUL: dec.op = rae_pkg::OP_MUL;
      rae_pkg::CMD_AND: dec.op = rae_pkg::OP_AND;
      rae_pkg::CMD_OR:  dec.op = rae_pkg::OP_OR;
      rae_pkg::CMD_XOR: dec.op = rae_pkg::OP_XOR;
      rae_pkg::CMD_CMP: dec.op = rae_pkg::OP_CMP;
      default:          dec.op = rae_pkg::OP_NOP;
    endcase
  end

  assign in_stall    = (cnt_r == QCW'(rae_pkg::QDEPTH));
  assign push        = in_valid && !in_stall;
  assign issue.valid = (cnt_r != '0);
  assign issue.beat  = q_mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QAW'(1);
      end
      if (issue_pop) begin
        rptr_r <= rptr_r + QAW'(1);
      end
      if (push && !issue_pop) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (!push && issue_pop) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

endmodule

// ----- sv/rae_back.sv -----
// ----------------------------------------------------------------------------
// Register ALU back end
// Reads operands from the register file, runs the operation (shift-add
// multiply and restoring divide one bit per cycle), writes back and loads
// the output register.
// ----------------------------------------------------------------------------
module rae_back #(
  parameter int NUM_REGS   = rae_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH = rae_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rae_pkg::issue_t    issue,
  output logic               issue_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rae_pkg::out_beat_t out_beat
);

  localparam int W  = DATA_WIDTH;
  localparam int RW = $clog2(NUM_REGS);
  localparam int CW = $clog2(DATA_WIDTH + 1);
  localparam int OW = rae_pkg::DEST_W;

  rae_pkg::bst_t      state_r, state_nxt;
  rae_pkg::op_t       op_r, op_nxt;
  logic [RW-1:0]      dst_r, dst_nxt;
  logic               use_imm_r, use_imm_nxt;
  logic [W-1:0]       imm_r, imm_nxt;
  logic               a_vld_r, a_vld_nxt;
  logic               b_vld_r, b_vld_nxt;
  logic [W:0]         acc_r, acc_nxt;
  logic [W-1:0]       opa_r, opa_nxt;
  logic [W-1:0]       opb_r, opb_nxt;
  logic               neg_r, neg_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [W-1:0]       res_r, res_nxt;
  logic               err_r, err_nxt;
  logic               gt_r, gt_nxt;
  logic               eq_r, eq_nxt;
  logic [NUM_REGS-1:0] vld_r, vld_nxt;
  logic               out_valid_r;
  rae_pkg::out_beat_t out_beat_r;

  logic [W-1:0] rd_a, rd_b;
  logic [W-1:0] a_val, b_val, a_mag, b_mag, alu_res, fin_res;
  logic [W:0]   rem_sh;
  logic         rem_ge;
  logic         out_free, out_load, ram_we, need_iter;
  logic [RW-1:0] rd_dst, rd_src;

  assign rd_dst = issue.beat.dest_index[RW-1:0];
  assign rd_src = issue.beat.src_index[RW-1:0];

  rae_ram #(
    .WIDTH(W),
    .DEPTH(NUM_REGS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (dst_r),
    .wdata   (fin_res),
    .raddr_a (rd_dst),
    .rdata_a (rd_a),
    .raddr_b (rd_src),
    .rdata_b (rd_b)
  );

  assign a_val     = a_vld_r ? rd_a : '0;
  assign b_val     = use_imm_r ? imm_r : (b_vld_r ? rd_b : '0);
  assign a_mag     = a_val[W-1] ? (W'(0) - a_val) : a_val;
  assign b_mag     = b_val[W-1] ? (W'(0) - b_val) : b_val;
  assign need_iter = (op_r == rae_pkg::OP_MUL) ||
                     ((op_r == rae_pkg::OP_DIV) && (b_val != '0));
  assign out_free  = !out_valid_r || !out_stall;
  assign rem_sh    = {acc_r[W-1:0], opa_r[W-1]};
  assign rem_ge    = (rem_sh >= {1'b0, opb_r});

  always_comb begin
    case (op_r)
      rae_pkg::OP_MOV: alu_res = b_val;
      rae_pkg::OP_ADD: alu_res = a_val + b_val;
      rae_pkg::OP_SUB: alu_res = a_val - b_val;
      rae_pkg::OP_AND: alu_res = a_val & b_val;
      rae_pkg::OP_OR:  alu_res = a_val | b_val;
      rae_pkg::OP_XOR: alu_res = a_val ^ b_val;
      default:         alu_res = a_val;
    endcase
  end

  always_comb begin
    case (op_r)
      rae_pkg::OP_DIV: fin_res = err_r ? res_r : (neg_r ? (W'(0) - opa_r) : opa_r);
      rae_pkg::OP_MUL: fin_res = acc_r[W-1:0];
      default:         fin_res = res_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rae_pkg::ST_IDLE: if (issue.valid) state_nxt = rae_pkg::ST_LOAD;
      rae_pkg::ST_LOAD: state_nxt = need_iter ? rae_pkg::ST_ITER : rae_pkg::ST_DONE;
      rae_pkg::ST_ITER: if (cnt_r == CW'(1)) state_nxt = rae_pkg::ST_DONE;
      rae_pkg::ST_DONE: if (out_free) state_nxt = rae_pkg::ST_IDLE;
      default:          state_nxt = rae_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    issue_pop = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      rae_pkg::ST_IDLE: issue_pop = issue.valid;
      rae_pkg::ST_DONE: out_load  = out_free;
      default: begin
        issue_pop = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  assign ram_we = out_load;

  always_comb begin
    op_nxt      = op_r;
    dst_nxt     = dst_r;
    use_imm_nxt = use_imm_r;
    imm_nxt     = imm_r;
    a_vld_nxt   = a_vld_r;
    b_vld_nxt   = b_vld_r;
    acc_nxt     = acc_r;
    opa_nxt     = opa_r;
    opb_nxt     = opb_r;
    neg_nxt     = neg_r;
    cnt_nxt     = cnt_r;
    res_nxt     = res_r;
    err_nxt     = err_r;
    gt_nxt      = gt_r;
    eq_nxt      = eq_r;
    vld_nxt     = vld_r;
    if (issue_pop) begin
      op_nxt      = issue.beat.op;
      dst_nxt     = rd_dst;
      use_imm_nxt = issue.beat.use_immediate;
      imm_nxt     = W'(issue.beat.imm_value);
      a_vld_nxt   = vld_r[rd_dst];
      b_vld_nxt   = vld_r[rd_src];
    end
    if (state_r == rae_pkg::ST_LOAD) begin
      res_nxt = alu_res;
      err_nxt = (op_r == rae_pkg::OP_DIV) && (b_val == '0);
      cnt_nxt = CW'(W);
      acc_nxt = '0;
      neg_nxt = a_val[W-1] ^ b_val[W-1];
      if (op_r == rae_pkg::OP_DIV) begin
        opa_nxt = a_mag;
        opb_nxt = b_mag;
      end else begin
        opa_nxt = a_val;
        opb_nxt = b_val;
      end
      if (op_r == rae_pkg::OP_CMP) begin
        gt_nxt = $signed(a_val) > $signed(b_val);
        eq_nxt = (a_val == b_val);
      end
    end
    if (state_r == rae_pkg::ST_ITER) begin
      cnt_nxt = cnt_r - CW'(1);
      if (op_r == rae_pkg::OP_DIV) begin
        acc_nxt = rem_ge ? (rem_sh - {1'b0, opb_r}) : rem_sh;
        opa_nxt = {opa_r[W-2:0], rem_ge};
      end else begin
        acc_nxt = opb_r[0] ? {1'b0, acc_r[W-1:0] + opa_r} : acc_r;
        opa_nxt = {opa_r[W-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[W-1:1]};
      end
    end
    if (ram_we) begin
      vld_nxt[dst_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    dst_r     <= dst_nxt;
    use_imm_r <= use_imm_nxt;
    imm_r     <= imm_nxt;
    a_vld_r   <= a_vld_nxt;
    b_vld_r   <= b_vld_nxt;
    acc_r     <= acc_nxt;
    opa_r     <= opa_nxt;
    opb_r     <= opb_nxt;
    neg_r     <= neg_nxt;
    cnt_r     <= cnt_nxt;
    res_r     <= res_nxt;
    err_r     <= err_nxt;
    if (out_load) begin
      out_beat_r.dest_value     <= OW'($signed(fin_res));
      out_beat_r.greater_flag   <= gt_r;
      out_beat_r.equal_flag     <= eq_r;
      out_beat_r.div_zero_error <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rae_pkg::ST_IDLE;
      vld_r       <= '0;
      gt_r        <= 1'b0;
      eq_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      gt_r    <= gt_nxt;
      eq_r    <= eq_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  a_iter_op: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rae_pkg::ST_ITER |-> (op_r == rae_pkg::OP_MUL || op_r == rae_pkg::OP_DIV))
    else $error("iteration running for an operation without one");

  a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
    issue_pop |=> state_r == rae_pkg::ST_LOAD)
    else $error("popped beat not loaded");

  a_iter_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rae_pkg::ST_ITER && cnt_r == CW'(1)) |=> state_r == rae_pkg::ST_DONE)
    else $error("iteration overran its count");

  a_err_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && err_r) |-> (op_r == rae_pkg::OP_DIV && fin_res == res_r))
    else $error("error flag outside a zero-divisor divide");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded beat not presented");

endmodule

// ----- tb/sv/register_alu_execute_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Register ALU execute core testbench
// Sends two-operand instructions through the valid/stall input channel and
// checks every result beat against an in-bench register file and flag model,
// with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module register_alu_execute_core_test;

  localparam int NREGS       = rae_pkg::NUM_REGS_DEF;
  localparam int DW          = rae_pkg::DATA_WIDTH_DEF;
  localparam int CMD_W       = rae_pkg::CMD_W;
  localparam int IDX_FIELD_W = rae_pkg::IDX_FIELD_W;
  localparam int IMM_W       = rae_pkg::IMM_W;
  localparam int IDLE_PCT    = 32;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 60;
  localparam int MAX_REPORTS = 10;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;
  localparam logic [IMM_W-1:0] IMM_MAX       = {IMM_W{1'b1}};

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  rae_pkg::in_beat_t  in_beat   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rae_pkg::out_beat_t out_beat;

  // instruction set state as seen from outside
  logic [DW-1:0] arch_regs [NREGS];
  logic          flag_gt;
  logic          flag_eq;

  rae_pkg::out_beat_t pending_results[$];
  int        fail_count   = 0;
  int        instr_count  = 0;
  int        result_count = 0;
  int        divzero_count = 0;
  bit        tx_idle_en   = 1'b1;
  bit        rx_idle_en   = 1'b1;
  logic      hold_active  = 1'b0;
  int        hold_len     = 0;
  event      hold_start;

  register_alu_execute_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic rae_pkg::out_beat_t exec_instr(rae_pkg::in_beat_t b);
    int                 d;
    int                 s;
    logic [DW-1:0]      a;
    logic [DW-1:0]      src;
    logic [DW-1:0]      r;
    logic [DW-1:0]      mag_a;
    logic [DW-1:0]      mag_b;
    logic [DW-1:0]      q;
    logic               dz;
    rae_pkg::out_beat_t res;
    d   = int'(b.dest_index) % NREGS;
    s   = int'(b.src_index) % NREGS;
    a   = arch_regs[d];
    src = b.use_immediate ? DW'({1'b0, b.imm_value}) : arch_regs[s];
    r   = a;
    dz  = 1'b0;
    case (b.cmd)
      rae_pkg::CMD_MOV: r = src;
      rae_pkg::CMD_ADD: r = a + src;
      rae_pkg::CMD_SUB: r = a - src;
      rae_pkg::CMD_DIV: begin
        if (src == '0) begin
          dz = 1'b1;
        end else begin
          mag_a = a[DW-1] ? -a : a;
          mag_b = src[DW-1] ? -src : src;
          q     = mag_a / mag_b;
          r     = (a[DW-1] ^ src[DW-1]) ? -q : q;
        end
      end
      rae_pkg::CMD_MUL: r = a * src;
      rae_pkg::CMD_AND: r = a & src;
      rae_pkg::CMD_OR:  r = a | src;
      rae_pkg::CMD_XOR: r = a ^ src;
      rae_pkg::CMD_CMP: begin
        flag_gt = $signed(a) > $signed(src);
        flag_eq = (a == src);
      end
      default: ;
    endcase
    arch_regs[d]       = r;
    res.dest_value     = r;
    res.greater_flag   = flag_gt;
    res.equal_flag     = flag_eq;
    res.div_zero_error = dz;
    return res;
  endfunction

  function automatic rae_pkg::in_beat_t mk_instr(logic [CMD_W-1:0] cmd, int d, bit imm_sel,
                                                 int s, logic [IMM_W-1:0] imm);
    rae_pkg::in_beat_t b;
    b.cmd           = cmd;
    b.dest_index    = IDX_FIELD_W'(d);
    b.use_immediate = imm_sel;
    b.src_index     = IDX_FIELD_W'(s);
    b.imm_value     = imm;
    return b;
  endfunction

  function automatic rae_pkg::in_beat_t rand_instr();
    logic [CMD_W-1:0] cmd;
    logic [IMM_W-1:0] imm;
    if ($urandom_range(99) < 6) begin
      cmd = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    end else begin
      cmd = CMD_W'($urandom_range(rae_pkg::CMD_CMP, rae_pkg::CMD_MOV));
    end
    case ($urandom_range(4))
      0: imm = IMM_W'($urandom_range(3));
      1: imm = IMM_MAX - IMM_W'($urandom_range(3));
      2: imm = IMM_W'($urandom());
      3: imm = IMM_W'($urandom_range(1000));
      default: imm = IMM_W'(1) << $urandom_range(IMM_W - 1);
    endcase
    return mk_instr(cmd, $urandom_range(7), 1'($urandom_range(1)), $urandom_range(7), imm);
  endfunction

  // hold valid and payload until the beat is taken, then predict its result
  task automatic send_instr(rae_pkg::in_beat_t b);
    rae_pkg::out_beat_t exp;
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    exp = exec_instr(b);
    pending_results.insert(pending_results.size(), exp);
    instr_count++;
    if (b.cmd == rae_pkg::CMD_DIV && exp.div_zero_error) begin
      divzero_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (pending_results.size() == 0) begin
        if (fail_count < MAX_REPORTS) begin
          $display("unexpected result beat: value %0d", out_beat.dest_value);
        end
        fail_count++;
      end else begin
        if (out_beat.dest_value !== pending_results[0].dest_value ||
            out_beat.greater_flag !== pending_results[0].greater_flag ||
            out_beat.equal_flag !== pending_results[0].equal_flag ||
            out_beat.div_zero_error !== pending_results[0].div_zero_error) begin
          if (fail_count < MAX_REPORTS) begin
            $display("mismatch on result %0d: expected value %0d gt %0b eq %0b dz %0b,",
                     result_count, pending_results[0].dest_value,
                     pending_results[0].greater_flag, pending_results[0].equal_flag,
                     pending_results[0].div_zero_error);
            $display("  got value %0d gt %0b eq %0b dz %0b", out_beat.dest_value,
                     out_beat.greater_flag, out_beat.equal_flag, out_beat.div_zero_error);
          end
          fail_count++;
        end
        void'(pending_results.pop_front());
      end
    end
    out_stall <= hold_active || (rx_idle_en && $urandom_range(99) < IDLE_PCT);
  end

  initial begin
    forever begin
      @(hold_start);
      for (int n = 0; n < hold_len; n++) begin
        hold_active <= 1'b1;
        @(posedge clk);
      end
      hold_active <= 1'b0;
    end
  end

  task automatic test_directed();
    send_instr(mk_instr(rae_pkg::CMD_MOV, 0, 1'b1, 0, IMM_MAX));
    send_instr(mk_instr(rae_pkg::CMD_ADD, 0, 1'b1, 0, 31'd1));
    send_instr(mk_instr(rae_pkg::CMD_MOV, 1, 1'b1, 0, 31'd0));
    send_instr(mk_instr(rae_pkg::CMD_SUB, 1, 1'b1, 0, 31'd1));
    send_instr(mk_instr(rae_pkg::CMD_DIV, 0, 1'b0, 1, 31'd0));
    send_instr(mk_instr(rae_pkg::CMD_MOV, 2, 1'b1, 0, IMM_MAX));
    send_instr(mk_instr(rae_pkg::CMD_MUL, 2, 1'b1, 0, IMM_MAX));
    send_instr(mk_instr(rae_pkg::CMD_DIV, 2, 1'b1, 0, 31'd0));
    send_instr(mk_instr(rae_pkg::CMD_MOV, 3, 1'b1, 0, 31'd7));
    send_instr(mk_instr(rae_pkg::CMD_SUB, 3, 1'b1, 0, 31'd14));
    send_instr(mk_instr(rae_pkg::CMD_DIV, 3, 1'b1, 0, 31'd2));
    send_instr(mk_instr(rae_pkg::CMD_DIV, 3, 1'b0, 4, 31'd0));
    send_instr(mk_instr(rae_pkg::CMD_CMP, 3, 1'b0, 3, 31'd0));
    send_instr(mk_instr(rae_pkg::CMD_CMP, 1, 1'b1, 0, 31'd5));
    send_instr(mk_instr(rae_pkg::CMD_CMP, 2, 1'b0, 3, 31'd0));
    send_instr(mk_instr(rae_pkg::CMD_AND, 2, 1'b1, 0, 31'h5555_5555));
    send_instr(mk_instr(rae_pkg::CMD_OR,  2, 1'b0, 1, 31'd0));
    send_instr(mk_instr(rae_pkg::CMD_XOR, 2, 1'b1, 0, IMM_MAX));
    send_instr(mk_instr(CMD_UNUSED_LO, 5, 1'b1, 2, IMM_MAX));
    send_instr(mk_instr(CMD_UNUSED_HI, 7, 1'b0, 7, 31'd0));
    send_instr(mk_instr(rae_pkg::CMD_MOV, 7, 1'b0, 0, 31'd0));
    send_instr(mk_instr(rae_pkg::CMD_MUL, 7, 1'b0, 7, 31'd0));
    send_instr(mk_instr(rae_pkg::CMD_DIV, 6, 1'b0, 0, 31'd0));
    send_instr(mk_instr(rae_pkg::CMD_MOV, 6, 1'b1, 0, 31'd1));
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      send_instr(rand_instr());
    end
  endtask

  task automatic test_no_idle(int n);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random(n);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // hold off the output long enough to fill the block and stall its input
  task automatic test_backpressure();
    hold_len = 400;
    -> hold_start;
    test_random(16);
  endtask

  task automatic drain_results();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      fail_count += pending_results.size();
    end
  endtask

  initial begin
    for (int r = 0; r < NREGS; r++) begin
      arch_regs[r] = '0;
    end
    flag_gt = 1'b0;
    flag_eq = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(450);
    test_no_idle(300);
    test_backpressure();
    test_random(230);
    drain_results();
    $display("Sent %0d instructions and checked %0d results, %0d of them divides by zero,",
             instr_count, result_count, divzero_count);
    $display("  with random idling on both sides, an idle-free run and a long output hold.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
